// ----- rtl/q2e_pkg.sv -----
// ----------------------------------------------------------------------------
// q2e_pkg
// Constants and the arctangent table shared by the quaternion to Euler
// angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

   localparam int CORDIC_STEPS_DEF    = 16;
   localparam int INPUT_FRAC_BITS_DEF = 14;

   localparam int TERM_FRAC  = 28;
   localparam int ANG_FRAC   = 30;
   localparam int OUT_FRAC   = 13;
   localparam int ATAN_LEN   = 24;
   localparam int SQRT_STEPS = 32;
   localparam int SQRT_W     = 64;

   localparam longint PI_Q30      = 64'sd3373259426;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint TWO_PI_Q30  = 64'sd6746518852;

   localparam int ROLL_LIM  = 25736;
   localparam int PITCH_LIM = 12868;
   localparam int YAW_MAX   = 51472;

   // atan(2^-i) in Q.30
   function automatic logic [29:0] atan_q30(input int idx);
      logic [29:0] v;
      case (idx)
         0:  v = 30'd843314856;
         1:  v = 30'd497837829;
         2:  v = 30'd263043836;
         3:  v = 30'd133525158;
         4:  v = 30'd67021686;
         5:  v = 30'd33543515;
         6:  v = 30'd16775850;
         7:  v = 30'd8388437;
         8:  v = 30'd4194282;
         9:  v = 30'd2097149;
         10: v = 30'd1048575;
         11: v = 30'd524287;
         12: v = 30'd262143;
         13: v = 30'd131071;
         14: v = 30'd65535;
         15: v = 30'd32767;
         16: v = 30'd16383;
         17: v = 30'd8191;
         18: v = 30'd4095;
         19: v = 30'd2047;
         20: v = 30'd1023;
         21: v = 30'd511;
         22: v = 30'd255;
         23: v = 30'd127;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/quaternion_to_euler_angles.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts an attitude quaternion to ZYX roll (Q3.13), pitch (Q2.13) and yaw (unsigned Q3.13).
// ----------------------------------------------------------------------------
// A fully pipelined converter: busy stays low, so a quaternion can be started
// on every clock. Each result appears on the rsp_ ports for one cycle with
// rsp_valid high. It passes the product registers, the term stage, the 32
// stages of the pitch square root (one root digit per stage), the pre-rotation
// and one CORDIC rotation per stage before the output registers.
// Results leave in start order and cannot be held off by the receiver.
// Non-unit quaternions are converted as given; a pitch term outside [-1, 1]
// is saturated and reported on rsp_pitch_clamped.
module quaternion_to_euler_angles
   import q2e_pkg::*;
#(
   parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
   parameter int INPUT_FRAC_BITS = INPUT_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_qw,
   input  logic signed [15:0] req_qx,
   input  logic signed [15:0] req_qy,
   input  logic signed [15:0] req_qz,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic        [15:0] rsp_yaw_angle,
   output logic               rsp_pitch_clamped
);

   localparam int SH_DOWN = (2 * INPUT_FRAC_BITS >= TERM_FRAC) ?
                            2 * INPUT_FRAC_BITS - TERM_FRAC : 0;
   localparam int SH_UP   = (2 * INPUT_FRAC_BITS < TERM_FRAC) ?
                            TERM_FRAC - 2 * INPUT_FRAC_BITS : 0;
   localparam int TW      = 35 + SH_UP;
   localparam int CW      = TW + 3;
   localparam int ZW      = 36;
   localparam int AW      = 38;
   localparam int RND_SH  = ANG_FRAC - OUT_FRAC;
   localparam int VLD_LEN = SQRT_STEPS + CORDIC_STEPS + 3;
   localparam int LAT     = VLD_LEN + 1;

   localparam int CH_ROLL  = 0;
   localparam int CH_PITCH = 1;
   localparam int CH_YAW   = 2;

   localparam logic signed [63:0] ONE_FULL = 64'sd1 <<< (2 * INPUT_FRAC_BITS);
   localparam logic signed [63:0] ONE_T    = 64'sd1 <<< TERM_FRAC;
   localparam logic signed [ZW-1:0] PI_Z   = ZW'(PI_Q30);
   localparam logic signed [AW-1:0] HALF_PI_A = AW'(HALF_PI_Q30);
   localparam logic signed [AW-1:0] TWO_PI_A  = AW'(TWO_PI_Q30);
   localparam logic signed [AW-1:0] RND_HALF  = AW'(64'sd1 <<< (RND_SH - 1));
   localparam logic signed [AW-1:0] ROLL_HI   = AW'(ROLL_LIM);
   localparam logic signed [AW-1:0] PITCH_HI  = AW'(PITCH_LIM);
   localparam logic signed [AW-1:0] YAW_HI    = AW'(YAW_MAX);

   typedef struct packed {
      logic                 clamped;
      logic signed [TW-1:0] sr;
      logic signed [TW-1:0] cr;
      logic signed [TW-1:0] sy;
      logic signed [TW-1:0] cy;
      logic [SQRT_W-1:0]    va;
      logic [SQRT_W-1:0]    ra;
      logic [SQRT_W-1:0]    vb;
      logic [SQRT_W-1:0]    rb;
   } sqrt_stage_type;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 zero;
   } cordic_ch_type;

   typedef struct packed {
      logic                    clamped;
      cordic_ch_type [2:0]     ch;
   } cordic_stage_type;

   function automatic logic signed [63:0] to_term(input logic signed [63:0] v);
      return (v >>> SH_DOWN) <<< SH_UP;
   endfunction

   function automatic cordic_ch_type cordic_pre(input logic signed [TW-1:0] y,
                                                input logic signed [TW-1:0] x);
      cordic_ch_type c;
      c.zero = (x == '0) && (y == '0);
      if (x < 0) begin
         c.x = -CW'(x);
         c.y = -CW'(y);
         c.z = (y >= 0) ? PI_Z : -PI_Z;
      end else begin
         c.x = CW'(x);
         c.y = CW'(y);
         c.z = '0;
      end
      return c;
   endfunction

   function automatic logic signed [AW-1:0] round_out(input logic signed [AW-1:0] v);
      logic signed [AW-1:0] t;
      t = v + RND_HALF;
      return t >>> RND_SH;
   endfunction

   logic                 accept;
   logic [VLD_LEN-1:0]   vld_ff;

   logic signed [31:0]   p_wx_in, p_yz_in, p_xx_in, p_yy_in, p_wz_in;
   logic signed [31:0]   p_xy_in, p_zz_in, p_wy_in, p_xz_in;
   logic signed [31:0]   p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_wz_ff;
   logic signed [31:0]   p_xy_ff, p_zz_ff, p_wy_ff, p_xz_ff;

   sqrt_stage_type       sq0_in;
   sqrt_stage_type       sq_in [1:SQRT_STEPS];
   sqrt_stage_type       sq_ff [0:SQRT_STEPS];

   cordic_stage_type     cd0_in;
   cordic_stage_type     cd_in [1:CORDIC_STEPS];
   cordic_stage_type     cd_ff [0:CORDIC_STEPS];

   logic                 rsp_valid_ff;
   logic signed [15:0]   roll_in, roll_ff;
   logic signed [14:0]   pitch_in, pitch_ff;
   logic [15:0]          yaw_in, yaw_ff;
   logic                 clamped_in, clamped_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // stage 1: products
   assign p_wx_in = req_qw * req_qx;
   assign p_yz_in = req_qy * req_qz;
   assign p_xx_in = req_qx * req_qx;
   assign p_yy_in = req_qy * req_qy;
   assign p_wz_in = req_qw * req_qz;
   assign p_xy_in = req_qx * req_qy;
   assign p_zz_in = req_qz * req_qz;
   assign p_wy_in = req_qw * req_qy;
   assign p_xz_in = req_qx * req_qz;

   // stage 2: terms, pitch saturation, root operands
   always_comb begin : term_stage
      logic signed [63:0] e_sr, e_cr, e_sy, e_cy, e_s, s_sat;
      logic [63:0]        a_op, b_op;
      e_sr = to_term((64'(p_wx_ff) + 64'(p_yz_ff)) <<< 1);
      e_cr = to_term(ONE_FULL - ((64'(p_xx_ff) + 64'(p_yy_ff)) <<< 1));
      e_sy = to_term((64'(p_wz_ff) + 64'(p_xy_ff)) <<< 1);
      e_cy = to_term(ONE_FULL - ((64'(p_yy_ff) + 64'(p_zz_ff)) <<< 1));
      e_s  = to_term((64'(p_wy_ff) - 64'(p_xz_ff)) <<< 1);
      sq0_in.clamped = 1'b0;
      if (e_s > ONE_T) begin
         s_sat = ONE_T;
         sq0_in.clamped = 1'b1;
      end else if (e_s < -ONE_T) begin
         s_sat = -ONE_T;
         sq0_in.clamped = 1'b1;
      end else begin
         s_sat = e_s;
      end
      a_op = 64'(ONE_T + s_sat);
      b_op = 64'(ONE_T - s_sat);
      sq0_in.sr = TW'(e_sr);
      sq0_in.cr = TW'(e_cr);
      sq0_in.sy = TW'(e_sy);
      sq0_in.cy = TW'(e_cy);
      sq0_in.va = a_op << TERM_FRAC;
      sq0_in.ra = '0;
      sq0_in.vb = b_op << TERM_FRAC;
      sq0_in.rb = '0;
   end

   // one root digit per stage
   always_comb begin : sqrt_steps
      logic [SQRT_W-1:0] bk, ta, tb;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         sq_in[k+1] = sq_ff[k];
         bk = SQRT_W'(1) << (SQRT_W - 2 - 2 * k);
         ta = sq_ff[k].ra + bk;
         tb = sq_ff[k].rb + bk;
         if (sq_ff[k].va >= ta) begin
            sq_in[k+1].va = sq_ff[k].va - ta;
            sq_in[k+1].ra = (sq_ff[k].ra >> 1) + bk;
         end else begin
            sq_in[k+1].ra = sq_ff[k].ra >> 1;
         end
         if (sq_ff[k].vb >= tb) begin
            sq_in[k+1].vb = sq_ff[k].vb - tb;
            sq_in[k+1].rb = (sq_ff[k].rb >> 1) + bk;
         end else begin
            sq_in[k+1].rb = sq_ff[k].rb >> 1;
         end
      end
   end

   // pre-rotation into the right half plane
   always_comb begin : cordic_prep
      cd0_in.clamped        = sq_ff[SQRT_STEPS].clamped;
      cd0_in.ch[CH_ROLL]    = cordic_pre(sq_ff[SQRT_STEPS].sr, sq_ff[SQRT_STEPS].cr);
      cd0_in.ch[CH_PITCH]   = cordic_pre(TW'(sq_ff[SQRT_STEPS].ra),
                                         TW'(sq_ff[SQRT_STEPS].rb));
      cd0_in.ch[CH_YAW]     = cordic_pre(sq_ff[SQRT_STEPS].sy, sq_ff[SQRT_STEPS].cy);
   end

   // one vectoring rotation per stage, three channels side by side
   always_comb begin : cordic_steps
      logic signed [CW-1:0] xs, ys;
      logic signed [ZW-1:0] at;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         cd_in[i+1] = cd_ff[i];
         at = ZW'(atan_q30(i));
         for (int j = 0; j < 3; j++) begin
            xs = cd_ff[i].ch[j].x >>> i;
            ys = cd_ff[i].ch[j].y >>> i;
            if (cd_ff[i].ch[j].y > 0) begin
               cd_in[i+1].ch[j].x = cd_ff[i].ch[j].x + ys;
               cd_in[i+1].ch[j].y = cd_ff[i].ch[j].y - xs;
               cd_in[i+1].ch[j].z = cd_ff[i].ch[j].z + at;
            end else begin
               cd_in[i+1].ch[j].x = cd_ff[i].ch[j].x - ys;
               cd_in[i+1].ch[j].y = cd_ff[i].ch[j].y + xs;
               cd_in[i+1].ch[j].z = cd_ff[i].ch[j].z - at;
            end
         end
      end
   end

   // final: pitch scaling, yaw wrap, rounding, limits
   always_comb begin : finish
      logic signed [AW-1:0] zr, zp, zy, rr, rp, ry;
      zr = cd_ff[CORDIC_STEPS].ch[CH_ROLL].zero  ? '0 :
           AW'(cd_ff[CORDIC_STEPS].ch[CH_ROLL].z);
      zp = cd_ff[CORDIC_STEPS].ch[CH_PITCH].zero ? '0 :
           AW'(cd_ff[CORDIC_STEPS].ch[CH_PITCH].z);
      zy = cd_ff[CORDIC_STEPS].ch[CH_YAW].zero   ? '0 :
           AW'(cd_ff[CORDIC_STEPS].ch[CH_YAW].z);
      zp = (zp <<< 1) - HALF_PI_A;
      if (zy < 0) begin
         zy = zy + TWO_PI_A;
      end
      if (zy > TWO_PI_A) begin
         zy = zy - TWO_PI_A;
      end
      rr = round_out(zr);
      rp = round_out(zp);
      ry = round_out(zy);
      if (rr > ROLL_HI) begin
         rr = ROLL_HI;
      end else if (rr < -ROLL_HI) begin
         rr = -ROLL_HI;
      end
      if (rp > PITCH_HI) begin
         rp = PITCH_HI;
      end else if (rp < -PITCH_HI) begin
         rp = -PITCH_HI;
      end
      if (ry > YAW_HI) begin
         ry = YAW_HI;
      end else if (ry < 0) begin
         ry = '0;
      end
      roll_in    = 16'(rr);
      pitch_in   = 15'(rp);
      yaw_in     = 16'(ry);
      clamped_in = cd_ff[CORDIC_STEPS].clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[VLD_LEN-2:0], accept};
         rsp_valid_ff <= vld_ff[VLD_LEN-1];
      end
   end

   always_ff @(posedge clock) begin
      p_wx_ff <= p_wx_in;
      p_yz_ff <= p_yz_in;
      p_xx_ff <= p_xx_in;
      p_yy_ff <= p_yy_in;
      p_wz_ff <= p_wz_in;
      p_xy_ff <= p_xy_in;
      p_zz_ff <= p_zz_in;
      p_wy_ff <= p_wy_in;
      p_xz_ff <= p_xz_in;
      sq_ff[0] <= sq0_in;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
         sq_ff[k] <= sq_in[k];
      end
      cd_ff[0] <= cd0_in;
      for (int i = 1; i <= CORDIC_STEPS; i++) begin
         cd_ff[i] <= cd_in[i];
      end
      roll_ff    <= roll_in;
      pitch_ff   <= pitch_in;
      yaw_ff     <= yaw_in;
      clamped_ff <= clamped_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_roll_angle    = roll_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_yaw_angle     = yaw_ff;
   assign rsp_pitch_clamped = clamped_ff;

   a_valid_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LAT))
      else $error("result beat without a matching start");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_roll_angle <= 16'(ROLL_LIM)) &&
                    (rsp_roll_angle >= -16'(ROLL_LIM)))
      else $error("roll out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= 15'(PITCH_LIM)) &&
                    (rsp_pitch_angle >= -15'(PITCH_LIM)))
      else $error("pitch out of range");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_yaw_angle <= 16'(YAW_MAX)))
      else $error("yaw out of range");

endmodule
